// File: hdl/fifb_pkg.sv
`timescale 1ns / 1ps

package fifb_pkg;

   localparam int ADDR_W = 20;
   localparam int HEAP_W = 21;
   localparam int HDR_W  = 8;

   localparam logic [ADDR_W-1:0] OFFSET_LIMIT = 20'hFFFFF;
   localparam logic [HEAP_W-1:0] HEAP_RESET   = 21'h100000;
   localparam logic [HDR_W-1:0]  HEADER_RESET = 8'd28;

   // csr register indexes
   localparam logic CSR_HEAP_BYTES   = 1'b0;
   localparam logic CSR_HEADER_BYTES = 1'b1;

   // request kinds
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK         = 2'd0,
      STAT_NO_SPACE   = 2'd1,
      STAT_TABLE_FULL = 2'd2,
      STAT_BAD_FREE   = 2'd3
   } status_type;

   // one block table entry
   typedef struct packed {
      logic              in_use;
      logic [ADDR_W-1:0] length;
      logic [ADDR_W-1:0] start;
   } entry_type;

   // finished transaction handed from the sequencer to the output stage
   typedef struct packed {
      logic              valid;
      logic [ADDR_W-1:0] payload;
      status_type        status;
   } result_type;

endpackage

// File: hdl/fifb_table.sv
`timescale 1ns / 1ps

module fifb_table #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic                clock,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output fifb_pkg::entry_type rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  fifb_pkg::entry_type wr_data
);

   fifb_pkg::entry_type table_ff [DEPTH];
   fifb_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/fifb_ctrl.sv
`timescale 1ns / 1ps

module fifb_ctrl #(
   parameter int MAX_BLOCKS = 64,
   parameter int AW         = 6,
   parameter int CW         = 7
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic                                op,
   input  logic [fifb_pkg::ADDR_W-1:0]         size,
   input  logic [fifb_pkg::ADDR_W-1:0]         addr,
   input  logic [fifb_pkg::HEAP_W-1:0]         heap_bytes,
   input  logic [fifb_pkg::HDR_W-1:0]          header_bytes,
   input  logic                                hdr_we,
   input  logic [fifb_pkg::HDR_W-1:0]          hdr_wdata,
   input  logic                                res_take,
   output logic                                idle,
   output fifb_pkg::result_type                res,
   output logic                                rd_en,
   output logic [AW-1:0]                       rd_addr,
   input  fifb_pkg::entry_type                 rd_data,
   output logic                                wr_en,
   output logic [AW-1:0]                       wr_addr,
   output fifb_pkg::entry_type                 wr_data
);

   localparam int AD = fifb_pkg::ADDR_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [CW-1:0]                 idx_ff, idx_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [AD-1:0]                 top_ff, top_in;
   logic                          op_ff, op_in;
   logic [AD-1:0]                 size_ff, size_in;
   logic [AD-1:0]                 addr_ff, addr_in;
   logic [AD-1:0]                 payload_ff, payload_in;
   fifb_pkg::status_type          status_ff, status_in;

   logic [CW-1:0]                 chk_idx;
   logic [AD-1:0]                 hit_payload;
   logic                          hit;
   logic [AD+1:0]                 end_sum;
   logic [fifb_pkg::HEAP_W-1:0]   limit;

   assign chk_idx     = idx_ff - CW'(1);
   assign hit_payload = rd_data.start + AD'(header_bytes);
   assign hit = (op_ff == fifb_pkg::OP_ALLOC)
              ? (!rd_data.in_use && (rd_data.length >= size_ff))
              : (rd_data.in_use && (hit_payload == addr_ff));

   assign end_sum = (AD+2)'(top_ff) + (AD+2)'(header_bytes) + (AD+2)'(size_ff);
   assign limit   = (heap_bytes > fifb_pkg::HEAP_W'(fifb_pkg::OFFSET_LIMIT))
                  ? fifb_pkg::HEAP_W'(fifb_pkg::OFFSET_LIMIT) : heap_bytes;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      top_in     = top_ff;
      op_in      = op_ff;
      size_in    = size_ff;
      addr_in    = addr_ff;
      payload_in = payload_ff;
      status_in  = status_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = chk_idx[AW-1:0];
      wr_data    = rd_data;

      unique case (state_ff)
         ST_IDLE: begin
            // a header change before any block exists moves the heap top
            if (hdr_we && (count_ff == '0)) begin
               top_in = AD'(hdr_wdata);
            end
            if (start) begin
               op_in   = op;
               size_in = size;
               addr_in = addr;
               if (count_ff == '0) begin
                  state_in = ST_DECIDE;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  idx_in   = CW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // rd_data holds entry idx_ff-1; next read is already issued here
            if (hit) begin
               wr_en          = 1'b1;
               wr_data.in_use = ~rd_data.in_use;
               payload_in     = (op_ff == fifb_pkg::OP_ALLOC) ? hit_payload : '0;
               status_in      = fifb_pkg::STAT_OK;
               state_in       = ST_DONE;
            end else if (idx_ff < count_ff) begin
               rd_en  = 1'b1;
               idx_in = idx_ff + CW'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            payload_in = '0;
            state_in   = ST_DONE;
            if (op_ff == fifb_pkg::OP_FREE) begin
               status_in = fifb_pkg::STAT_BAD_FREE;
            end else if (end_sum > (AD+2)'(limit)) begin
               status_in = fifb_pkg::STAT_NO_SPACE;
            end else if (count_ff == CW'(MAX_BLOCKS)) begin
               status_in = fifb_pkg::STAT_TABLE_FULL;
            end else begin
               wr_en          = 1'b1;
               wr_addr        = count_ff[AW-1:0];
               wr_data.start  = top_ff;
               wr_data.length = size_ff;
               wr_data.in_use = 1'b1;
               count_in       = count_ff + CW'(1);
               payload_in     = top_ff + AD'(header_bytes);
               top_in         = end_sum[AD-1:0];
               status_in      = fifb_pkg::STAT_OK;
            end
         end
         ST_DONE: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         top_ff   <= AD'(fifb_pkg::HEADER_RESET);
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         top_ff   <= top_in;
      end
      op_ff      <= op_in;
      size_ff    <= size_in;
      addr_ff    <= addr_in;
      payload_ff <= payload_in;
      status_ff  <= status_in;
   end

   assign idle        = (state_ff == ST_IDLE);
   assign res.valid   = (state_ff == ST_DONE);
   assign res.payload = payload_ff;
   assign res.status  = status_ff;

endmodule

// File: hdl/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps

// Channel | Direction | Ports                           | Contents
// req     | in        | req_tvalid/tready/tdata/tuser   | alloc or free request
// rsp     | out       | rsp_tvalid/tready/tdata         | payload offset and status
// csr     | in        | csr_we/csr_index/csr_wdata      | heap_bytes, header_bytes
//
// One transaction at a time. A request that matches table entry k is answered
// once the scan has read entries 0 to k; a miss (append, failure or bad free)
// is decided after all block_count entries, at most MAX_BLOCKS, are read. The
// next request is taken once the result has left the sequencer. The single
// read port of the block table, one entry per cycle, sets the scan length.
// Reset is synchronous and clears control state only; the table itself is
// never cleared, entries at or above block_count are never read.
// A result waits in the rsp register; the next request is taken meanwhile,
// and its result holds in the sequencer until the register is free.

module first_fit_block_allocator_top #(
   parameter int MAX_BLOCKS = 64
) (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [19:0] request_size, [39:20] free_address
   input  logic        req_tuser,   // [0] op
   // response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] payload_address, [21:20] status, rest 0
   // configuration
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [20:0] csr_wdata
);

   localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int AD = fifb_pkg::ADDR_W;

   logic [fifb_pkg::HEAP_W-1:0] heap_bytes_ff, heap_bytes_in;
   logic [fifb_pkg::HDR_W-1:0]  header_ff, header_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [AD-1:0]               rsp_addr_ff, rsp_addr_in;
   fifb_pkg::status_type        rsp_status_ff, rsp_status_in;

   logic                        accept;
   logic                        hdr_we;
   logic                        idle;
   logic                        res_take;
   fifb_pkg::result_type        res;

   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   fifb_pkg::entry_type         rd_data;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   fifb_pkg::entry_type         wr_data;

   assign accept = req_tvalid && req_tready;
   assign hdr_we = csr_we && (csr_index == fifb_pkg::CSR_HEADER_BYTES);

   // config registers
   always_comb begin
      heap_bytes_in = heap_bytes_ff;
      header_in     = header_ff;
      if (csr_we) begin
         case (csr_index)
            fifb_pkg::CSR_HEAP_BYTES:   heap_bytes_in = csr_wdata;
            fifb_pkg::CSR_HEADER_BYTES: header_in     = csr_wdata[fifb_pkg::HDR_W-1:0];
            default: ;
         endcase
      end
   end

   // output register: loads when empty or being drained
   assign res_take = res.valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      if (res_take) begin
         rsp_valid_in  = 1'b1;
         rsp_addr_in   = res.payload;
         rsp_status_in = res.status;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= fifb_pkg::HEAP_RESET;
         header_ff     <= fifb_pkg::HEADER_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_bytes_ff <= heap_bytes_in;
         header_ff     <= header_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
   end

   fifb_ctrl #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (accept),
      .op           (req_tuser),
      .size         (req_tdata[19:0]),
      .addr         (req_tdata[39:20]),
      .heap_bytes   (heap_bytes_ff),
      .header_bytes (header_ff),
      .hdr_we       (hdr_we),
      .hdr_wdata    (csr_wdata[fifb_pkg::HDR_W-1:0]),
      .res_take     (res_take),
      .idle         (idle),
      .res          (res),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data)
   );

   fifb_table #(
      .DEPTH (MAX_BLOCKS),
      .AW    (AW)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_tready = idle;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_status_ff, rsp_addr_ff};

   // an accepted transaction keeps the sequencer busy in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_tready)
      else $error("sequencer idle right after accepting a transaction");

   // a finished result never coexists with an idle sequencer
   a_result_not_idle: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> !idle)
      else $error("result pending while sequencer idle");

   // failed transactions always answer with a zero payload offset
   a_fail_zero_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != fifb_pkg::STAT_OK)) |-> (rsp_addr_ff == '0))
      else $error("failed transaction carries a payload offset");

endmodule

// File: bench/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps

// Checks the first-fit allocator end to end. A shadow copy of the block table
// predicts every response. Each request predicts its response when it is
// accepted, and each response is compared with the oldest prediction.
module tb_first_fit_block_allocator_top;

   localparam int MAX_BLOCKS     = 64;
   localparam int SETTLE_CYCLES  = MAX_BLOCKS + 8;   // worst scan plus margin
   localparam int RSP_HOLD       = 300;              // long back-pressure stretch
   localparam int STALL_LIMIT    = 5000;             // cycles with no transaction
   localparam int IDLE_PCT       = 26;
   localparam int PHASES         = 13;
   localparam int PHASE_ITEMS    = 100;
   localparam int AD             = fifb_pkg::ADDR_W;
   localparam int HW             = fifb_pkg::HEAP_W;
   localparam int DW             = fifb_pkg::HDR_W;

   // one predicted response
   typedef struct {
      logic [AD-1:0]        payload;
      fifb_pkg::status_type status;
   } outcome_type;

   // Shadow of the block table. It predicts each response and checks the
   // actual ones against the predictions.
   class heap_predictor;
      logic [AD-1:0]     slot_start[MAX_BLOCKS];
      logic [AD-1:0]     slot_length[MAX_BLOCKS];
      bit                slot_busy[MAX_BLOCKS];
      int unsigned       slot_count;
      logic [AD-1:0]     heap_top;
      logic [HW-1:0]     heap_bytes;
      logic [DW-1:0]     header_bytes;
      outcome_type       awaited[$];
      int unsigned       mismatches;

      function new();
         heap_bytes   = fifb_pkg::HEAP_RESET;
         header_bytes = fifb_pkg::HEADER_RESET;
         heap_top     = AD'(fifb_pkg::HEADER_RESET);
         slot_count   = 0;
         mismatches   = 0;
      endfunction

      function logic [AD-1:0] payload_of(int k);
         return AD'(slot_start[k] + header_bytes);
      endfunction

      function void write_reg(logic idx, logic [HW-1:0] value);
         if (idx == fifb_pkg::CSR_HEAP_BYTES) begin
            heap_bytes = value;
         end else begin
            header_bytes = value[DW-1:0];
            // the heap top follows the header only while the table is empty
            if (slot_count == 0) begin
               heap_top = AD'(header_bytes);
            end
         end
      endfunction

      function void note_request(logic op, logic [AD-1:0] size,
                                 logic [AD-1:0] addr);
         outcome_type want;
         int          k;
         int unsigned limit;
         int unsigned block_end;
         want.payload = '0;
         want.status  = fifb_pkg::STAT_OK;
         k = -1;
         if (op == fifb_pkg::OP_ALLOC) begin
            for (int i = 0; i < slot_count; i++) begin
               if (k < 0 && !slot_busy[i] && slot_length[i] >= size) begin
                  k = i;
               end
            end
            if (k >= 0) begin
               slot_busy[k] = 1'b1;
               want.payload = payload_of(k);
            end else begin
               limit = heap_bytes;
               if (limit > fifb_pkg::OFFSET_LIMIT) begin
                  limit = fifb_pkg::OFFSET_LIMIT;
               end
               block_end = heap_top + header_bytes + size;
               // running out of heap wins over a full table
               if (block_end > limit) begin
                  want.status = fifb_pkg::STAT_NO_SPACE;
               end else if (slot_count >= MAX_BLOCKS) begin
                  want.status = fifb_pkg::STAT_TABLE_FULL;
               end else begin
                  slot_start[slot_count]  = heap_top;
                  slot_length[slot_count] = size;
                  slot_busy[slot_count]   = 1'b1;
                  slot_count++;
                  want.payload = AD'(heap_top + header_bytes);
                  heap_top = AD'(block_end);
               end
            end
         end else begin
            for (int i = 0; i < slot_count; i++) begin
               if (k < 0 && slot_busy[i] && payload_of(i) == addr) begin
                  k = i;
               end
            end
            if (k >= 0) begin
               slot_busy[k] = 1'b0;
            end else begin
               want.status = fifb_pkg::STAT_BAD_FREE;
            end
         end
         awaited.push_back(want);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic [AD-1:0] payload, fifb_pkg::status_type status);
         outcome_type want;
         if (awaited.size() == 0) begin
            report($sformatf("response with none pending: payload %h status %0d",
                             payload, status));
            return;
         end
         want = awaited.pop_front();
         if (payload !== want.payload) begin
            report($sformatf("payload %h, predicted %h", payload, want.payload));
         end
         if (status !== want.status) begin
            report($sformatf("status %0d, predicted %0d", status, want.status));
         end
      endtask
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;    // [19:0] request_size, [39:20] free_address
   logic        req_tuser  = 1'b0;  // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;          // [19:0] payload_address, [21:20] status
   logic        csr_we     = 1'b0;
   logic        csr_index  = 1'b0;
   logic [20:0] csr_wdata  = '0;

   heap_predictor sb;
   bit            steady;       // both sides run without idle cycles
   int            hold_asked;   // back-pressure stretches requested
   int            hold_done;    // back-pressure stretches served
   int unsigned   quiet_cycles;

   first_fit_block_allocator_top #(
      .MAX_BLOCKS(MAX_BLOCKS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Response side: random ready, with one long hold when asked. The hold
   // is timed here so the request side keeps pushing into a full block.
   always begin
      @(posedge clock);
      if (hold_asked != hold_done) begin
         hold_done++;
         rsp_tready <= 1'b0;
         repeat (RSP_HOLD) @(posedge clock);
      end
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Every accepted response is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_response(rsp_tdata[19:0], fifb_pkg::status_type'(rsp_tdata[21:20]));
      end
   end

   // Watchdog: the run dies if no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic logic [AD-1:0] noise();
      return AD'($urandom);
   endfunction

   // Offers one request, with random idle cycles ahead of it, and returns
   // at the edge that accepts it. tvalid stays high for the next call.
   task automatic send_request(logic op, logic [AD-1:0] size,
                               logic [AD-1:0] addr);
      while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {addr, size};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, size, addr);
   endtask

   // Stop offering, let every pending response come back, then give the
   // longest scan time to settle before touching the registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [20:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly well-formed traffic: allocations of small or recycled sizes and
   // frees of live blocks; the rest is double frees, junk addresses and
   // oversized requests.
   task automatic random_request();
      logic              op;
      logic [AD-1:0]     size;
      logic [AD-1:0]     addr;
      int                k;
      int                r;
      int                pick;
      size = noise();
      addr = noise();
      r = $urandom_range(0, 99);
      if (r < 50) begin
         op   = fifb_pkg::OP_ALLOC;
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            size = AD'($urandom_range(0, 1023));
         end else if (pick < 75 && sb.slot_count > 0) begin
            // exact size of a known block, or one byte over
            k    = $urandom_range(0, sb.slot_count - 1);
            size = sb.slot_length[k] + AD'($urandom_range(0, 1));
         end else if (pick < 82) begin
            size = '0;
         end else if (pick < 96) begin
            size = AD'($urandom_range(0, 65535));
         end
      end else begin
         op = fifb_pkg::OP_FREE;
         if (r < 95 && sb.slot_count > 0) begin
            k = $urandom_range(0, sb.slot_count - 1);
            if (r < 90) begin
               // walk to a live block if there is one
               for (int n = 0; n < sb.slot_count && !sb.slot_busy[k]; n++) begin
                  k = (k + 1) % sb.slot_count;
               end
            end
            addr = sb.payload_of(k);
         end
      end
      send_request(op, size, addr);
   endtask

   initial begin
      logic [DW-1:0]  hdr_value;
      logic [HW-1:0]  heap_value;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Header writes on an empty table move the heap top; then a tiny heap.
      write_csr(fifb_pkg::CSR_HEADER_BYTES, 21'd0);
      write_csr(fifb_pkg::CSR_HEADER_BYTES, 21'd255);
      write_csr(fifb_pkg::CSR_HEAP_BYTES, 21'd1000);
      send_request(fifb_pkg::OP_FREE, noise(), 20'd0);        // free on empty table
      send_request(fifb_pkg::OP_ALLOC, 20'd0, noise());       // zero-length block
      send_request(fifb_pkg::OP_ALLOC, 20'hFFFFF, noise());   // largest request
      send_request(fifb_pkg::OP_ALLOC, 20'd235, noise());     // ends exactly at heap end
      send_request(fifb_pkg::OP_ALLOC, 20'd0, noise());       // heap exhausted
      send_request(fifb_pkg::OP_FREE, noise(), 20'd510);
      send_request(fifb_pkg::OP_FREE, noise(), 20'd510);      // double free
      send_request(fifb_pkg::OP_ALLOC, 20'd1, noise());       // free block too short
      send_request(fifb_pkg::OP_ALLOC, 20'd0, noise());       // reuse first block
      send_request(fifb_pkg::OP_FREE, noise(), 20'd765);
      send_request(fifb_pkg::OP_ALLOC, 20'd235, noise());     // reuse on exact length
      send_request(fifb_pkg::OP_FREE, noise(), 20'hFFFFF);    // junk address
      drain();

      // Header shrinks under live blocks: payload offsets move with it.
      write_csr(fifb_pkg::CSR_HEADER_BYTES, 21'd0);
      write_csr(fifb_pkg::CSR_HEAP_BYTES, fifb_pkg::HEAP_RESET);
      send_request(fifb_pkg::OP_FREE, noise(), 20'd510);
      send_request(fifb_pkg::OP_FREE, noise(), 20'd765);      // stale offset
      // one byte past the 20-bit offset range, with heap_bytes above it
      send_request(fifb_pkg::OP_ALLOC, AD'(21'h100000 - sb.heap_top), noise());
      send_request(fifb_pkg::OP_ALLOC, 20'd0, noise());

      // Random phases, each under its own register settings.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p % 4)
            0: hdr_value = fifb_pkg::HEADER_RESET;
            1: hdr_value = 8'd255;
            2: hdr_value = DW'($urandom);
            default: hdr_value = 8'd0;
         endcase
         case (p % 5)
            1: heap_value = HW'(sb.heap_top + $urandom_range(0, 4096));
            2: heap_value = '0;
            3: heap_value = HW'($urandom_range(0, 21'h100000));
            default: heap_value = fifb_pkg::HEAP_RESET;
         endcase
         write_csr(fifb_pkg::CSR_HEADER_BYTES, 21'(hdr_value));
         write_csr(fifb_pkg::CSR_HEAP_BYTES, heap_value);
         steady = (p == 6);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == 20) begin
               hold_asked++;
            end
            if (p == 8 && n == 50) begin
               drain();
            end
            random_request();
         end
      end
      steady = 1'b0;

      // By now the table is full: a fit at the offset limit reports a full
      // table, one byte more reports no space.
      drain();
      write_csr(fifb_pkg::CSR_HEADER_BYTES, 21'd0);
      write_csr(fifb_pkg::CSR_HEAP_BYTES, fifb_pkg::HEAP_RESET);
      send_request(fifb_pkg::OP_ALLOC, AD'(fifb_pkg::OFFSET_LIMIT - sb.heap_top), noise());
      send_request(fifb_pkg::OP_ALLOC, AD'(fifb_pkg::OFFSET_LIMIT - sb.heap_top + 1),
                   noise());
      send_request(fifb_pkg::OP_ALLOC, 20'hFFFFF, noise());
      drain();

      if (sb.awaited.size() != 0) begin
         sb.report("requests left without a response");
      end
      if (sb.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
